FILE: design/mdvd_pkg.sv
package mdvd_pkg;

  // Geometry of the codebook
  localparam int VECTOR_LEN    = 4;
  localparam int CODEBOOK_SIZE = 16;
  localparam int STORE_DEPTH   = VECTOR_LEN * CODEBOOK_SIZE;

  // Derived widths
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int POS_W  = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int CW_W   = $clog2(CODEBOOK_SIZE);
  localparam int DIST_W = 33 + $clog2(VECTOR_LEN);

  // Fixed field widths
  localparam int SMP_W   = 16;
  localparam int WORD_W  = 2 * SMP_W;
  localparam int SQ_W    = 32;
  localparam int ENTRY_W = 6;
  localparam int SYM_W   = 4;
  localparam int WIN_W   = 16;
  localparam int REP_W   = 17;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd16000;
  localparam logic [WIN_W-1:0] COUNT_MAX    = 16'hFFFF;

  // Command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // One sample pair held in a chain cell; real part in the low half
  typedef struct packed {
    logic [WORD_W-1:0] pri_word;
    logic [WORD_W-1:0] ref_word;
  } pair_t;

  // Sweep control traveling with each codebook word
  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic [CW_W-1:0] cw;
  } sweep_ctl_t;

endpackage

FILE: design/mdvd_ram.sv
module mdvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/mdvd_cell.sv
module mdvd_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  mdvd_pkg::pair_t d_in,
  output mdvd_pkg::pair_t q
);

  import mdvd_pkg::*;

  pair_t data_r;

  // Take the neighbor's pair on each shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign q = data_r;

endmodule

FILE: design/mdvd_dist.sv
module mdvd_dist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mdvd_pkg::sweep_ctl_t        ctl,
  input  logic [mdvd_pkg::WORD_W-1:0] smp,
  input  logic [mdvd_pkg::WORD_W-1:0] cbw,
  output logic [mdvd_pkg::CW_W-1:0]   best,
  output logic                        done
);

  import mdvd_pkg::*;

  logic signed [SMP_W:0]     d_re;
  logic signed [SMP_W:0]     d_im;
  logic signed [2*SMP_W+1:0] p_re;
  logic signed [2*SMP_W+1:0] p_im;

  sweep_ctl_t        ctl_a_r;
  logic [SQ_W-1:0]   sq_re_r;
  logic [SQ_W-1:0]   sq_im_r;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] acc_nxt;
  logic [DIST_W-1:0] dist_r;
  logic              dist_vld_r;
  logic [CW_W-1:0]   dist_cw_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [CW_W-1:0]   best_r;
  logic              done_r;

  // Exact differences and squares of both parts
  assign d_re = $signed({smp[SMP_W-1], smp[SMP_W-1:0]})
              - $signed({cbw[SMP_W-1], cbw[SMP_W-1:0]});
  assign d_im = $signed({smp[WORD_W-1], smp[WORD_W-1:SMP_W]})
              - $signed({cbw[WORD_W-1], cbw[WORD_W-1:SMP_W]});
  assign p_re = d_re * d_re;
  assign p_im = d_im * d_im;

  always_ff @(posedge clk) begin
    sq_re_r <= p_re[SQ_W-1:0];
    sq_im_r <= p_im[SQ_W-1:0];
  end

  // Accumulate one codeword's distance, restart on its first word
  assign acc_nxt = (ctl_a_r.first ? '0 : acc_r)
                 + DIST_W'(sq_re_r) + DIST_W'(sq_im_r);

  always_ff @(posedge clk) begin
    if (ctl_a_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (ctl_a_r.valid && ctl_a_r.last) begin
      dist_r    <= acc_nxt;
      dist_cw_r <= ctl_a_r.cw;
    end
  end

  // Keep the smallest distance; lowest index wins ties
  always_ff @(posedge clk) begin
    if (dist_vld_r && (dist_cw_r == '0 || dist_r < best_dist_r)) begin
      best_dist_r <= dist_r;
      best_r      <= dist_cw_r;
    end
  end

  // Control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r    <= '0;
      dist_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      ctl_a_r    <= ctl;
      dist_vld_r <= ctl_a_r.valid && ctl_a_r.last;
      done_r     <= dist_vld_r && (dist_cw_r == CW_W'(CODEBOOK_SIZE - 1));
    end
  end

  assign best = best_r;
  assign done = done_r;

endmodule

FILE: design/min_distance_vector_decoder.sv
// Load items and non-final samples are accepted while the sequencer is idle.
// The last sample of a vector starts a sweep of the whole codebook through its one read
// port, one word a cycle. out_valid rises once the sweep has drained and the result is
// registered. Input stalls until then, so no new vector is taken while one is in flight.
// Reset (rst_n low, synchronous) clears counters and handshakes and sets window_length to
// 16000; the codebook is undefined until loaded.
module min_distance_vector_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [mdvd_pkg::ENTRY_W-1:0] in_entry_address,
  input  logic signed [mdvd_pkg::SMP_W-1:0] in_sample_re,
  input  logic signed [mdvd_pkg::SMP_W-1:0] in_sample_im,
  input  logic signed [mdvd_pkg::SMP_W-1:0] in_ref_re,
  input  logic signed [mdvd_pkg::SMP_W-1:0] in_ref_im,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mdvd_pkg::SYM_W-1:0]   out_symbol,
  output logic [mdvd_pkg::SYM_W-1:0]   out_ref_symbol,
  output logic                         out_mismatch,
  output logic                         out_report_valid,
  output logic [mdvd_pkg::REP_W-1:0]   out_error_report,
  input  logic                         cfg_wr_en,
  input  logic [mdvd_pkg::WIN_W-1:0]   cfg_wr_data
);

  import mdvd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DRAIN, S_EMIT} state_t;

  state_t            state_r;
  logic [POS_W-1:0]  samp_pos_r;
  logic [POS_W-1:0]  pos_r;
  logic [CW_W-1:0]   cw_r;
  logic [ADDR_W-1:0] addr_r;
  logic [WIN_W-1:0]  win_len_r;
  logic [WIN_W-1:0]  wc_r;
  logic [WIN_W-1:0]  ec_r;
  logic [WIN_W-1:0]  wc_nxt;
  logic [WIN_W-1:0]  ec_nxt;

  logic              out_valid_r;
  logic [SYM_W-1:0]  out_symbol_r;
  logic [SYM_W-1:0]  out_ref_symbol_r;
  logic              out_mismatch_r;
  logic              out_report_valid_r;
  logic [REP_W-1:0]  out_error_report_r;

  logic              in_acc;
  logic              samp_acc;
  logic              samp_last;
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [WORD_W-1:0] ram_rd_data;
  logic              pos_last;
  logic              out_free;
  logic              mis;
  logic              report;

  sweep_ctl_t        ctl_issue;
  sweep_ctl_t        ctl_q_r;
  pair_t             new_pair;
  pair_t             chain_q [VECTOR_LEN];
  pair_t             chain_d [VECTOR_LEN];
  logic              shift_en;

  logic [CW_W-1:0]   best_pri;
  logic [CW_W-1:0]   best_ref;
  logic              pri_done;
  logic              ref_done;

  // Input handshake
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign samp_acc  = in_acc && (in_command == CMD_SAMPLE);
  assign samp_last = (samp_pos_r == POS_W'(VECTOR_LEN - 1));
  assign ram_wr_en = in_acc && (in_command == CMD_LOAD)
                  && (32'(in_entry_address) < 32'(STORE_DEPTH));

  // Codebook memory
  mdvd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_codebook (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ADDR_W'(in_entry_address)),
    .wr_data ({in_sample_im, in_sample_re}),
    .rd_en   (ram_rd_en),
    .rd_addr (addr_r),
    .rd_data (ram_rd_data)
  );

  // Issue one codebook read per sweep cycle
  assign pos_last        = (pos_r == POS_W'(VECTOR_LEN - 1));
  assign ram_rd_en       = (state_r == S_SWEEP);
  assign ctl_issue.valid = (state_r == S_SWEEP);
  assign ctl_issue.first = (pos_r == '0);
  assign ctl_issue.last  = pos_last;
  assign ctl_issue.cw    = cw_r;

  // Align control with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_q_r <= '0;
    end else begin
      ctl_q_r <= ctl_issue;
    end
  end

  // Sample chain: shift in new pairs, rotate once per codebook word
  assign new_pair.pri_word = {in_sample_im, in_sample_re};
  assign new_pair.ref_word = {in_ref_im, in_ref_re};
  assign shift_en          = samp_acc || ctl_q_r.valid;

  for (genvar i = 0; i < VECTOR_LEN; i++) begin : g_chain
    if (i == VECTOR_LEN - 1) begin : g_tail
      assign chain_d[i] = samp_acc ? new_pair : chain_q[0];
    end else begin : g_body
      assign chain_d[i] = chain_q[i + 1];
    end
    mdvd_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (chain_d[i]),
      .q        (chain_q[i])
    );
  end

  // Distance units, one per stream
  mdvd_dist u_dist_pri (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_q_r),
    .smp   (chain_q[0].pri_word),
    .cbw   (ram_rd_data),
    .best  (best_pri),
    .done  (pri_done)
  );

  mdvd_dist u_dist_ref (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_q_r),
    .smp   (chain_q[0].ref_word),
    .cbw   (ram_rd_data),
    .best  (best_ref),
    .done  (ref_done)
  );

  // Window and mismatch counters
  assign out_free = !out_valid_r || !out_stall;
  assign mis      = (best_pri != best_ref);
  assign wc_nxt   = wc_r + 1'b1;
  assign ec_nxt   = (mis && ec_r != COUNT_MAX) ? ec_r + 1'b1 : ec_r;
  assign report   = (wc_nxt == win_len_r);

  // Sequencer with output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      samp_pos_r  <= '0;
      pos_r       <= '0;
      cw_r        <= '0;
      addr_r      <= '0;
      win_len_r   <= WINDOW_RESET;
      wc_r        <= '0;
      ec_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_len_r <= cfg_wr_data;
      end
      // Drop the result beat once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (samp_acc) begin
            if (samp_last) begin
              samp_pos_r <= '0;
              pos_r      <= '0;
              cw_r       <= '0;
              addr_r     <= '0;
              state_r    <= S_SWEEP;
            end else begin
              samp_pos_r <= samp_pos_r + 1'b1;
            end
          end
        end
        S_SWEEP: begin
          addr_r <= addr_r + 1'b1;
          if (pos_last) begin
            pos_r <= '0;
            cw_r  <= cw_r + 1'b1;
            if (cw_r == CW_W'(CODEBOOK_SIZE - 1)) begin
              state_r <= S_DRAIN;
            end
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (pri_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_symbol_r       <= SYM_W'(best_pri);
            out_ref_symbol_r   <= SYM_W'(best_ref);
            out_mismatch_r     <= mis;
            out_report_valid_r <= report;
            if (report) begin
              out_error_report_r <= {ec_nxt, 1'b0};
              wc_r               <= '0;
              ec_r               <= '0;
            end else begin
              out_error_report_r <= '0;
              wc_r               <= wc_nxt;
              ec_r               <= ec_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_ref_symbol   = out_ref_symbol_r;
  assign out_mismatch     = out_mismatch_r;
  assign out_report_valid = out_report_valid_r;
  assign out_error_report = out_error_report_r;

  // Checks
  a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> !ram_wr_en)
    else $error("codebook written during a sweep");

  a_units_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    pri_done == ref_done)
    else $error("distance units out of step");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_report_valid_r) |-> (out_error_report_r == '0))
    else $error("error report set outside a window close");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");

endmodule
